>>> rtl/smp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable two-way merge path: shared definitions
// Sizes, function codes and transaction types used by the merge path block.
// ----------------------------------------------------------------------------
package smp_pkg;

    localparam int RUN_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(RUN_DEPTH);
    localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
    localparam int POS_W     = 11;
    localparam int KEY_W     = 32;
    localparam int WIDE_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef enum logic [1:0] {
        FUNC_APPEND_A = 2'd0,
        FUNC_APPEND_B = 2'd1,
        FUNC_CLEAR    = 2'd2,
        FUNC_QUERY    = 2'd3
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   value;
        logic [POS_W-1:0]   position;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   out_key;
        logic [KEY_W-1:0]   out_value;
        logic               from_run_a;
        logic               in_range;
        logic               overflowed;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   value;
    } pair_t;

endpackage

>>> rtl/smp_run_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable two-way merge path: run store
// Holds one run of key and value pairs, with one write and one registered
// read port.
// ----------------------------------------------------------------------------
module smp_run_store (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [smp_pkg::ADDR_W-1:0] wr_addr,
    input  smp_pkg::pair_t             wr_pair,
    input  logic                       rd_en,
    input  logic [smp_pkg::ADDR_W-1:0] rd_addr,
    output smp_pkg::pair_t             rd_pair
);
    import smp_pkg::*;

    pair_t mem [RUN_DEPTH];
    pair_t rd_pair_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_pair;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_pair_reg <= mem[rd_addr];
        end
    end

    assign rd_pair = rd_pair_reg;

endmodule

>>> rtl/stable_two_way_merge_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable two-way merge path
// Holds two ascending runs of key and value pairs and returns the pair at a
// given position of their stable merge, in which run A wins ties.
//
// The item channel (item_valid, item_stall, item) carries appends to run A
// or run B, a clear of both runs, or a position query. The result channel
// (result_valid, result_stall, result) returns one transaction per query;
// appends and clears give none and do not stall the item channel. A query
// is accepted and loads the search bounds, then issues the first memory
// read, then runs the binary search (at most eleven steps, one memory read
// per step) and ends with the final compare. The item channel stalls while
// a query is in progress. A finished result sits in an output register, so
// the next item is taken while it waits; a query whose result finds that
// register still full holds at its final step until the receiver takes it.
// Reset empties both runs and clears the sticky overflow flag; the run
// memories themselves are not cleared, and no entry beyond a count is used.
// ----------------------------------------------------------------------------
module stable_two_way_merge_path (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  smp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output smp_pkg::result_t result
);
    import smp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_FINAL  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_a_reg, count_a_next;
    logic [CNT_W-1:0]    count_b_reg, count_b_next;
    logic                overflow_reg, overflow_next;
    logic [WIDE_W-1:0]   lo_reg, lo_next;
    logic [WIDE_W-1:0]   hi_reg, hi_next;
    logic [WIDE_W-1:0]   mid_reg, mid_next;
    logic [WIDE_W-1:0]   pos_reg, pos_next;
    logic                in_range_reg, in_range_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic                accept;
    logic                full_a, full_b;
    logic                wr_en_a, wr_en_b;
    pair_t               wr_pair;
    pair_t               rd_a, rd_b;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;

    logic [WIDE_W-1:0]   na_w, nb_w, pos_in;
    logic [WIDE_W-1:0]   lo_init, hi_init;
    logic [WIDE_W-1:0]   jm;
    logic [KEY_W-1:0]    b_here;
    logic [WIDE_W-1:0]   lo_upd, hi_upd;
    logic [WIDE_W-1:0]   lo_sel, hi_sel;
    logic [WIDE_W-1:0]   span, mid_n, addr_a_w, addr_b_w, j_fin;
    logic                search_more;
    logic                take_a, load_result;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    assign full_a  = (count_a_reg >= CNT_W'(RUN_DEPTH));
    assign full_b  = (count_b_reg >= CNT_W'(RUN_DEPTH));
    assign wr_en_a = accept && (item.func == FUNC_APPEND_A) && !full_a;
    assign wr_en_b = accept && (item.func == FUNC_APPEND_B) && !full_b;
    assign wr_pair = '{key: item.key, value: item.value};

    assign na_w   = WIDE_W'(count_a_reg);
    assign nb_w   = WIDE_W'(count_b_reg);
    assign pos_in = WIDE_W'(item.position);

    assign lo_init = (pos_in > nb_w) ? (pos_in - nb_w) : '0;
    assign hi_init = (pos_in < na_w) ? pos_in : na_w;

    // One search step: compare the last A key before the split with the B
    // key after it, a missing B entry counting as the largest key.
    assign jm            = pos_reg - mid_reg;
    assign b_here        = (jm < nb_w) ? rd_b.key : KEY_MAX;
    assign lo_upd        = (rd_a.key > b_here) ? lo_reg : mid_reg;
    assign hi_upd        = (rd_a.key > b_here) ? (mid_reg - WIDE_W'(1)) : hi_reg;

    assign lo_sel      = (state_reg == ST_SEARCH) ? lo_upd : lo_reg;
    assign hi_sel      = (state_reg == ST_SEARCH) ? hi_upd : hi_reg;
    assign search_more = (lo_sel < hi_sel);
    assign span        = hi_sel - lo_sel + WIDE_W'(1);
    assign mid_n       = lo_sel + (span >> 1);
    assign addr_a_w    = search_more ? (mid_n - WIDE_W'(1)) : lo_sel;
    assign addr_b_w    = search_more ? (pos_reg - mid_n) : (pos_reg - lo_sel);
    assign rd_addr_a   = addr_a_w[ADDR_W-1:0];
    assign rd_addr_b   = addr_b_w[ADDR_W-1:0];
    assign rd_en       = (state_reg == ST_START) || (state_reg == ST_SEARCH);

    assign j_fin = pos_reg - lo_reg;

    always_comb
    begin
        priority if (lo_reg >= na_w)
        begin
            take_a = 1'b0;
        end
        else if (j_fin >= nb_w)
        begin
            take_a = 1'b1;
        end
        else
        begin
            take_a = (rd_a.key <= rd_b.key);
        end
    end

    assign load_result = (state_reg == ST_FINAL) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next    = state_reg;
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        overflow_next = overflow_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        pos_next      = pos_reg;
        in_range_next = in_range_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.func)
                        FUNC_APPEND_A:
                        begin
                            if (full_a)
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                count_a_next = count_a_reg + CNT_W'(1);
                            end
                        end
                        FUNC_APPEND_B:
                        begin
                            if (full_b)
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                count_b_next = count_b_reg + CNT_W'(1);
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_a_next = '0;
                            count_b_next = '0;
                        end
                        FUNC_QUERY:
                        begin
                            lo_next       = lo_init;
                            hi_next       = hi_init;
                            pos_next      = pos_in;
                            in_range_next = (pos_in < (na_w + nb_w));
                            state_next    = ST_START;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_START, ST_SEARCH:
            begin
                lo_next  = lo_sel;
                hi_next  = hi_sel;
                mid_next = mid_n;
                state_next = search_more ? ST_SEARCH : ST_FINAL;
            end
            ST_FINAL:
            begin
                if (load_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next = result_reg;
        if (load_result)
        begin
            result_next.overflowed = overflow_reg;
            result_next.in_range   = in_range_reg;
            if (!in_range_reg)
            begin
                result_next.out_key    = '0;
                result_next.out_value  = '0;
                result_next.from_run_a = 1'b0;
            end
            else if (take_a)
            begin
                result_next.out_key    = rd_a.key;
                result_next.out_value  = rd_a.value;
                result_next.from_run_a = 1'b1;
            end
            else
            begin
                result_next.out_key    = rd_b.key;
                result_next.out_value  = rd_b.value;
                result_next.from_run_a = 1'b0;
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_a_reg      <= '0;
            count_b_reg      <= '0;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_a_reg      <= count_a_next;
            count_b_reg      <= count_b_next;
            overflow_reg     <= overflow_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        pos_reg      <= pos_next;
        in_range_reg <= in_range_next;
        result_reg   <= result_next;
    end

    smp_run_store u_run_a (
        .clk     (clk),
        .wr_en   (wr_en_a),
        .wr_addr (count_a_reg[ADDR_W-1:0]),
        .wr_pair (wr_pair),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_pair (rd_a)
    );

    smp_run_store u_run_b (
        .clk     (clk),
        .wr_en   (wr_en_b),
        .wr_addr (count_b_reg[ADDR_W-1:0]),
        .wr_pair (wr_pair),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_pair (rd_b)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> tb/stable_two_way_merge_path_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable two-way merge path: testbench
// Appends pairs to both runs, clears them and queries merged positions. A
// local model of the runs and of the merge-path search predicts every query
// result. A checker compares each result transaction, field by field, with the
// oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module stable_two_way_merge_path_tb;

    import smp_pkg::*;

    localparam int RANDOM_GOAL = 400;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    logic [KEY_W-1:0] a_keys   [RUN_DEPTH];
    logic [KEY_W-1:0] a_values [RUN_DEPTH];
    logic [KEY_W-1:0] b_keys   [RUN_DEPTH];
    logic [KEY_W-1:0] b_values [RUN_DEPTH];
    int unsigned      a_count = 0;
    int unsigned      b_count = 0;
    logic             overflow_seen = 1'b0;

    result_t merged_expected [$];
    bit      idle_on = 1'b1;
    int      items_sent = 0;
    int      queries_checked = 0;
    int      error_count = 0;
    int      stall_hold = 0;

    stable_two_way_merge_path DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic item_t make_item(input func_t f, input logic [KEY_W-1:0] k,
                                        input logic [KEY_W-1:0] v, input int unsigned p);
        item_t it;
        it.func     = f;
        it.key      = k;
        it.value    = v;
        it.position = p[POS_W-1:0];
        return it;
    endfunction

    function automatic logic [KEY_W-1:0] bump_key(input logic [KEY_W-1:0] k,
                                                  input logic [KEY_W-1:0] step);
        logic [KEY_W:0] s;
        s = {1'b0, k} + {1'b0, step};
        return s[KEY_W] ? KEY_MAX : s[KEY_W-1:0];
    endfunction

    function automatic void merge_lookup(input item_t it);
        result_t     r;
        int unsigned na, nb, p, lo, hi, mid, jm, i, j;
        logic [KEY_W-1:0] a_prev, b_here;
        logic        take_a;
        r = '0;
        na = a_count;
        nb = b_count;
        p = it.position;
        case (it.func)
            FUNC_APPEND_A:
            begin
                if (a_count >= RUN_DEPTH)
                    overflow_seen = 1'b1;
                else
                begin
                    a_keys[a_count] = it.key;
                    a_values[a_count] = it.value;
                    a_count++;
                end
            end
            FUNC_APPEND_B:
            begin
                if (b_count >= RUN_DEPTH)
                    overflow_seen = 1'b1;
                else
                begin
                    b_keys[b_count] = it.key;
                    b_values[b_count] = it.value;
                    b_count++;
                end
            end
            FUNC_CLEAR:
            begin
                a_count = 0;
                b_count = 0;
            end
            default:
            begin
                if (p < na + nb)
                begin
                    r.in_range = 1'b1;
                    lo = (p > nb) ? p - nb : 0;
                    hi = (p < na) ? p : na;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo + 1) / 2;
                        jm = p - mid;
                        a_prev = a_keys[mid - 1];
                        b_here = (jm < nb) ? b_keys[jm] : KEY_MAX;
                        if (a_prev > b_here)
                            hi = mid - 1;
                        else
                            lo = mid;
                    end
                    i = lo;
                    j = p - i;
                    if (i >= na)
                        take_a = 1'b0;
                    else if (j >= nb)
                        take_a = 1'b1;
                    else
                        take_a = (a_keys[i] <= b_keys[j]);
                    r.from_run_a = take_a;
                    r.out_key    = take_a ? a_keys[i] : b_keys[j];
                    r.out_value  = take_a ? a_values[i] : b_values[j];
                end
                r.overflowed = overflow_seen;
                merged_expected.push_back(r);
            end
        endcase
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        merge_lookup(it);
        items_sent++;
    endtask

    task automatic send_query(input int unsigned p);
        send_item(make_item(FUNC_QUERY, $urandom, $urandom, p));
    endtask

    task automatic send_clear();
        send_item(make_item(FUNC_CLEAR, $urandom, $urandom, $urandom_range(0, 2047)));
    endtask

    always @(posedge clk)
    begin
        if (stall_hold > 0)
            stall_hold--;
        else
        begin
            result_stall <= idle_on && ($urandom_range(0, 2) == 0);
            stall_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (merged_expected.size() == 0)
            begin
                $display("%0t: unexpected result transaction %h", $time, result);
                error_count++;
            end
            else
            begin
                want = merged_expected.pop_front();
                queries_checked++;
                if (result.out_key !== want.out_key)
                begin
                    $display("%0t: out_key expected %h actual %h",
                             $time, want.out_key, result.out_key);
                    error_count++;
                end
                if (result.out_value !== want.out_value)
                begin
                    $display("%0t: out_value expected %h actual %h",
                             $time, want.out_value, result.out_value);
                    error_count++;
                end
                if (result.from_run_a !== want.from_run_a)
                begin
                    $display("%0t: from_run_a expected %b actual %b",
                             $time, want.from_run_a, result.from_run_a);
                    error_count++;
                end
                if (result.in_range !== want.in_range)
                begin
                    $display("%0t: in_range expected %b actual %b",
                             $time, want.in_range, result.in_range);
                    error_count++;
                end
                if (result.overflowed !== want.overflowed)
                begin
                    $display("%0t: overflowed expected %b actual %b",
                             $time, want.overflowed, result.overflowed);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_queries();
        send_query(0);
        send_query(2047);
        send_clear();
        send_query(0);
    endtask

    task automatic test_ties_and_extremes();
        send_item(make_item(FUNC_APPEND_A, 32'h0000_0000, 32'hFFFF_FFFF, 2047));
        send_item(make_item(FUNC_APPEND_B, 32'h0000_0000, 32'h1234_5678, 0));
        send_item(make_item(FUNC_APPEND_A, 32'h0000_0005, 32'h0000_0000, 1024));
        send_item(make_item(FUNC_APPEND_B, 32'h0000_0005, 32'h5555_AAAA, 1023));
        send_item(make_item(FUNC_APPEND_A, KEY_MAX, 32'hAAAA_5555, 0));
        send_item(make_item(FUNC_APPEND_B, KEY_MAX, 32'h8000_0001, 2047));
        for (int p = 0; p <= 6; p++)
            send_query(p);
    endtask

    task automatic test_unsorted_runs();
        send_clear();
        send_item(make_item(FUNC_APPEND_A, 32'd9, 32'hDEAD_0001, 5));
        send_item(make_item(FUNC_APPEND_A, 32'd3, 32'hDEAD_0002, 6));
        send_item(make_item(FUNC_APPEND_B, 32'd5, 32'hDEAD_0003, 7));
        for (int p = 0; p <= 3; p++)
            send_query(p);
    endtask

    task automatic test_random_merges();
        int          na, nb, ia, ib, nq, mode;
        bit          sorted_runs;
        logic [KEY_W-1:0] ka, kb, step_max;
        int unsigned p;
        while (items_sent < RANDOM_GOAL)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 2);
            sorted_runs = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 7) != 0)
                send_clear();
            if ($urandom_range(0, 9) == 0)
            begin
                na = $urandom_range(0, 60);
                nb = $urandom_range(0, 60);
            end
            else
            begin
                na = $urandom_range(0, 12);
                nb = $urandom_range(0, 12);
            end
            case (mode)
                0:
                begin
                    ka = $urandom_range(0, 3);
                    step_max = 2;
                end
                1:
                begin
                    ka = $urandom_range(0, 1000);
                    step_max = 32'h0100_0000;
                end
                default:
                begin
                    ka = KEY_MAX - $urandom_range(0, 6);
                    step_max = 3;
                end
            endcase
            kb = (mode == 1) ? $urandom_range(0, 1000) : ka;
            ia = 0;
            ib = 0;
            while (ia < na || ib < nb)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_query($urandom_range(0, ia + ib));
                if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1))
                begin
                    send_item(make_item(FUNC_APPEND_A, ka, $urandom, $urandom_range(0, 2047)));
                    ka = sorted_runs ? bump_key(ka, $urandom_range(0, step_max)) : $urandom;
                    ia++;
                end
                else
                begin
                    send_item(make_item(FUNC_APPEND_B, kb, $urandom, $urandom_range(0, 2047)));
                    kb = sorted_runs ? bump_key(kb, $urandom_range(0, step_max)) : $urandom;
                    ib++;
                end
            end
            nq = $urandom_range(1, na + nb + 2);
            repeat (nq)
            begin
                p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                : $urandom_range(0, na + nb);
                send_query(p);
            end
        end
    endtask

    task automatic test_run_overflow();
        logic [KEY_W-1:0] k;
        send_clear();
        k = $urandom_range(0, 100);
        for (int n = 0; n < RUN_DEPTH; n++)
        begin
            if (n % 128 == 0)
                idle_on = ($urandom_range(0, 1) == 1);
            send_item(make_item(FUNC_APPEND_A, k, $urandom, $urandom_range(0, 2047)));
            k = bump_key(k, $urandom_range(0, 3_000_000));
        end
        idle_on = 1'b1;
        send_query(0);
        send_item(make_item(FUNC_APPEND_A, 32'd1, 32'hBAD0_0001, 3));
        send_item(make_item(FUNC_APPEND_A, KEY_MAX, 32'hBAD0_0002, 4));
        send_query(RUN_DEPTH - 1);
        send_query(RUN_DEPTH);
        k = 0;
        for (int n = 0; n < 12; n++)
        begin
            send_item(make_item(FUNC_APPEND_B, k, $urandom, $urandom_range(0, 2047)));
            k = bump_key(k, $urandom_range(0, 32'h2000_0000));
        end
        send_query(0);
        send_query(RUN_DEPTH + 11);
        send_query(RUN_DEPTH + 12);
        send_query(2047);
        repeat (20)
            send_query($urandom_range(0, RUN_DEPTH + 11));
        send_clear();
        send_query(0);
        send_item(make_item(FUNC_APPEND_B, 32'd7, 32'h0BAD_F00D, 2047));
        send_query(0);
        send_query(1);
    endtask

    initial
    begin
        int wait_cycles;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queries();
        test_ties_and_extremes();
        test_unsorted_runs();
        test_random_merges();
        test_run_overflow();
        item_valid <= 1'b0;
        wait_cycles = 0;
        while (merged_expected.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (merged_expected.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, merged_expected.size());
            error_count++;
        end
        repeat (30) @(posedge clk);
        $display("Sent %0d item transactions; checked %0d query results, %0d errors.",
                 items_sent, queries_checked, error_count);
        $display("Covered empty runs, ties, extreme keys, unsorted runs and run overflow.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
